// File: sv/srci_pkg.sv
`default_nettype none

package srci_pkg;

    localparam int COORD_BITS = 24;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic signed [COORD_BITS-1:0] rect_left;
        logic signed [COORD_BITS-1:0] rect_bottom;
        logic [COORD_BITS-2:0]        rect_width;
        logic [COORD_BITS-2:0]        rect_height;
    } seg_in_t;

    typedef struct packed {
        logic                         hit;
        logic signed [COORD_BITS-1:0] cross_x;
        logic signed [COORD_BITS-1:0] cross_y;
    } seg_out_t;

endpackage

`default_nettype wire

// File: sv/srci_div.sv
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// Expects num < den * 2**W so the quotient fits in W bits.
module srci_div #(
    parameter int W  = srci_pkg::COORD_BITS,
    parameter int SW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [2*W-1:0]  num,
    input  logic [W-1:0]    den,
    input  logic [SW-1:0]   side,
    output logic            out_valid,
    output logic [W-1:0]    quo,
    output logic            rem_nz,
    output logic [SW-1:0]   out_side
);

    logic [W-1:0]  rem_reg  [W];
    logic [W-1:0]  lo_reg   [W];
    logic [W-1:0]  q_reg    [W];
    logic [W-1:0]  den_reg  [W];
    logic [SW-1:0] side_reg [W];
    logic [W-1:0]  valid_reg;

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [W-1:0]  rem_in;
        logic [W-1:0]  lo_in;
        logic [W-1:0]  q_in;
        logic [W-1:0]  den_in;
        logic [SW-1:0] side_in;
        logic          v_in;
        logic [W:0]    trial;
        logic [W:0]    diff;
        logic          ge;
        logic [W-1:0]  rem_next;

        if (k == 0) begin : g_first
            assign rem_in  = num[2*W-1:W];
            assign lo_in   = num[W-1:0];
            assign q_in    = '0;
            assign den_in  = den;
            assign side_in = side;
            assign v_in    = in_valid;
        end
        else begin : g_later
            assign rem_in  = rem_reg[k-1];
            assign lo_in   = lo_reg[k-1];
            assign q_in    = q_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign side_in = side_reg[k-1];
            assign v_in    = valid_reg[k-1];
        end

        assign trial    = {rem_in, lo_in[W-1]};
        assign diff     = trial - {1'b0, den_in};
        assign ge       = trial >= {1'b0, den_in};
        assign rem_next = ge ? diff[W-1:0] : trial[W-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                lo_reg[k]   <= {lo_in[W-2:0], 1'b0};
                q_reg[k]    <= {q_in[W-2:0], ge};
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[W-1];
    assign quo       = q_reg[W-1];
    assign rem_nz    = |rem_reg[W-1];
    assign out_side  = side_reg[W-1];

endmodule

`default_nettype wire

// File: sv/segment_rectangle_clip_intersect.sv
`default_nettype none

// Segment versus rectangle crossing point (Liang-Barsky clipping).
// Input channel in_valid/in_stall/in_data carries one segment and one
// axis-aligned rectangle per item; output channel out_valid/out_stall/out_data
// returns one result per item: hit and the first crossing point strictly
// inside the segment, rounded toward minus infinity, zero when there is none.
// Five stages of edge setup, cross-multiplied ratio compares, selection and a
// product come first, then one stage per quotient bit of the pipelined divider,
// then the output register. Throughput is one item per cycle while the output
// is not stalled; the divider is fully pipelined.
// Reset clears every valid bit; the pipeline comes out of reset empty and
// ready. When the receiver stalls with a result waiting, the whole pipeline
// holds and in_stall rises in the same cycle; nothing is lost or repeated.
module segment_rectangle_clip_intersect (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  srci_pkg::seg_in_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output srci_pkg::seg_out_t  out_data
);

    localparam int C  = srci_pkg::COORD_BITS;
    localparam int W  = C + 2;
    localparam int P  = 2 * W;
    localparam int SW = 2 * C + 3;

    logic en;
    logic out_valid_reg;
    srci_pkg::seg_out_t out_data_reg;

    assign en        = !out_valid_reg || !out_stall;
    assign in_stall  = !en;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ---------------- stage 1: edge distances
    logic signed [W-1:0] ax_w, ay_w, bx_w, by_w, rx_w, ry_w, rw_w, rh_w;
    logic signed [W-1:0] dx_w, dy_w, ndx_w, ndy_w, qxl, qxh, qyl, qyh;
    logic signed [W-1:0] s1_ex_next, s1_xx_next, s1_ey_next, s1_xy_next;
    logic [C-1:0]        s1_adx_next, s1_ady_next;
    logic                s1_xlim_next, s1_ylim_next, s1_rej_next;

    assign ax_w = {{2{in_data.start_x[C-1]}}, in_data.start_x};
    assign ay_w = {{2{in_data.start_y[C-1]}}, in_data.start_y};
    assign bx_w = {{2{in_data.end_x[C-1]}}, in_data.end_x};
    assign by_w = {{2{in_data.end_y[C-1]}}, in_data.end_y};
    assign rx_w = {{2{in_data.rect_left[C-1]}}, in_data.rect_left};
    assign ry_w = {{2{in_data.rect_bottom[C-1]}}, in_data.rect_bottom};
    assign rw_w = {3'b000, in_data.rect_width};
    assign rh_w = {3'b000, in_data.rect_height};

    assign dx_w  = bx_w - ax_w;
    assign dy_w  = by_w - ay_w;
    assign ndx_w = -dx_w;
    assign ndy_w = -dy_w;
    assign qxl   = rx_w - ax_w;
    assign qxh   = rx_w + rw_w - ax_w;
    assign qyl   = ry_w - ay_w;
    assign qyh   = ry_w + rh_w - ay_w;

    // entry and exit numerators share the denominator |d| of their axis
    assign s1_ex_next   = dx_w[W-1] ? -qxh : qxl;
    assign s1_xx_next   = dx_w[W-1] ? -qxl : qxh;
    assign s1_ey_next   = dy_w[W-1] ? -qyh : qyl;
    assign s1_xy_next   = dy_w[W-1] ? -qyl : qyh;
    assign s1_adx_next  = dx_w[W-1] ? ndx_w[C-1:0] : dx_w[C-1:0];
    assign s1_ady_next  = dy_w[W-1] ? ndy_w[C-1:0] : dy_w[C-1:0];
    assign s1_xlim_next = (dx_w != 0);
    assign s1_ylim_next = (dy_w != 0);
    // parallel to an axis and outside the slab
    assign s1_rej_next  = (!s1_xlim_next && (qxl > 0 || qxh < 0))
                       || (!s1_ylim_next && (qyl > 0 || qyh < 0));

    logic                s1_valid_reg;
    logic [C-1:0]        s1_ax_reg, s1_ay_reg, s1_adx_reg, s1_ady_reg;
    logic                s1_dxn_reg, s1_dyn_reg, s1_xlim_reg, s1_ylim_reg, s1_rej_reg;
    logic signed [W-1:0] s1_ex_reg, s1_xx_reg, s1_ey_reg, s1_xy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ax_reg   <= in_data.start_x;
            s1_ay_reg   <= in_data.start_y;
            s1_dxn_reg  <= dx_w[W-1];
            s1_dyn_reg  <= dy_w[W-1];
            s1_adx_reg  <= s1_adx_next;
            s1_ady_reg  <= s1_ady_next;
            s1_ex_reg   <= s1_ex_next;
            s1_xx_reg   <= s1_xx_next;
            s1_ey_reg   <= s1_ey_next;
            s1_xy_reg   <= s1_xy_next;
            s1_xlim_reg <= s1_xlim_next;
            s1_ylim_reg <= s1_ylim_next;
            s1_rej_reg  <= s1_rej_next;
        end
    end

    // ---------------- stage 2: cross products
    logic signed [P-1:0] s2_pex_next, s2_pxx_next, s2_pey_next, s2_pxy_next;
    logic                s2_rej_next;

    assign s2_pex_next = s1_ex_reg * $signed({1'b0, s1_ady_reg});
    assign s2_pxx_next = s1_xx_reg * $signed({1'b0, s1_ady_reg});
    assign s2_pey_next = s1_ey_reg * $signed({1'b0, s1_adx_reg});
    assign s2_pxy_next = s1_xy_reg * $signed({1'b0, s1_adx_reg});
    // entry past 1 or exit before 0
    assign s2_rej_next = s1_rej_reg
        || (s1_xlim_reg && (s1_ex_reg > $signed({2'b00, s1_adx_reg}) || s1_xx_reg < 0))
        || (s1_ylim_reg && (s1_ey_reg > $signed({2'b00, s1_ady_reg}) || s1_xy_reg < 0));

    logic                s2_valid_reg;
    logic [C-1:0]        s2_ax_reg, s2_ay_reg, s2_adx_reg, s2_ady_reg;
    logic                s2_dxn_reg, s2_dyn_reg, s2_xlim_reg, s2_ylim_reg, s2_rej_reg;
    logic signed [W-1:0] s2_ex_reg, s2_xx_reg, s2_ey_reg, s2_xy_reg;
    logic signed [P-1:0] s2_pex_reg, s2_pxx_reg, s2_pey_reg, s2_pxy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_ax_reg   <= s1_ax_reg;
            s2_ay_reg   <= s1_ay_reg;
            s2_dxn_reg  <= s1_dxn_reg;
            s2_dyn_reg  <= s1_dyn_reg;
            s2_adx_reg  <= s1_adx_reg;
            s2_ady_reg  <= s1_ady_reg;
            s2_ex_reg   <= s1_ex_reg;
            s2_xx_reg   <= s1_xx_reg;
            s2_ey_reg   <= s1_ey_reg;
            s2_xy_reg   <= s1_xy_reg;
            s2_xlim_reg <= s1_xlim_reg;
            s2_ylim_reg <= s1_ylim_reg;
            s2_rej_reg  <= s2_rej_next;
            s2_pex_reg  <= s2_pex_next;
            s2_pxx_reg  <= s2_pxx_next;
            s2_pey_reg  <= s2_pey_next;
            s2_pxy_reg  <= s2_pxy_next;
        end
    end

    // ---------------- stage 3: pick latest entry and earliest exit
    logic                s3_rej_next, s3_has_next, s3_entx_next, s3_extx_next;
    logic signed [W-1:0] s3_entn_next, s3_extn_next;
    logic [C-1:0]        s3_entd_next, s3_extd_next;

    assign s3_rej_next  = s2_rej_reg || (s2_xlim_reg && s2_ylim_reg
                       && (s2_pex_reg > s2_pxy_reg || s2_pey_reg > s2_pxx_reg));
    assign s3_has_next  = s2_xlim_reg || s2_ylim_reg;
    assign s3_entx_next = s2_xlim_reg && (!s2_ylim_reg || s2_pex_reg >= s2_pey_reg);
    assign s3_extx_next = s2_xlim_reg && (!s2_ylim_reg || s2_pxx_reg <= s2_pxy_reg);
    assign s3_entn_next = s3_entx_next ? s2_ex_reg : s2_ey_reg;
    assign s3_entd_next = s3_entx_next ? s2_adx_reg : s2_ady_reg;
    assign s3_extn_next = s3_extx_next ? s2_xx_reg : s2_xy_reg;
    assign s3_extd_next = s3_extx_next ? s2_adx_reg : s2_ady_reg;

    logic                s3_valid_reg;
    logic [C-1:0]        s3_ax_reg, s3_ay_reg, s3_adx_reg, s3_ady_reg;
    logic                s3_dxn_reg, s3_dyn_reg, s3_rej_reg, s3_has_reg;
    logic                s3_entx_reg, s3_extx_reg;
    logic signed [W-1:0] s3_entn_reg, s3_extn_reg;
    logic [C-1:0]        s3_entd_reg, s3_extd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (en)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_ax_reg   <= s2_ax_reg;
            s3_ay_reg   <= s2_ay_reg;
            s3_dxn_reg  <= s2_dxn_reg;
            s3_dyn_reg  <= s2_dyn_reg;
            s3_adx_reg  <= s2_adx_reg;
            s3_ady_reg  <= s2_ady_reg;
            s3_rej_reg  <= s3_rej_next;
            s3_has_reg  <= s3_has_next;
            s3_entx_reg <= s3_entx_next;
            s3_extx_reg <= s3_extx_next;
            s3_entn_reg <= s3_entn_next;
            s3_entd_reg <= s3_entd_next;
            s3_extn_reg <= s3_extn_next;
            s3_extd_reg <= s3_extd_next;
        end
    end

    // ---------------- stage 4: choose parameter, exact coordinate on its axis
    logic         t0_ok, t1_ok, sel_x;
    logic [C-1:0] sel_n, ebase;
    logic         eneg;
    logic         s4_hit_next;
    logic [C-1:0] s4_d_next, s4_exact_next, s4_obase_next, s4_omag_next;
    logic         s4_oneg_next;

    assign t0_ok = s3_has_reg && s3_entn_reg > 0
                && s3_entn_reg < $signed({2'b00, s3_entd_reg});
    assign t1_ok = s3_has_reg && s3_extn_reg > 0
                && s3_extn_reg < $signed({2'b00, s3_extd_reg});
    assign s4_hit_next = !s3_rej_reg && (t0_ok || t1_ok);
    assign sel_x = t0_ok ? s3_entx_reg : s3_extx_reg;
    assign sel_n = t0_ok ? s3_entn_reg[C-1:0] : s3_extn_reg[C-1:0];
    assign s4_d_next = t0_ok ? s3_entd_reg : s3_extd_reg;
    assign ebase = sel_x ? s3_ax_reg : s3_ay_reg;
    assign eneg  = sel_x ? s3_dxn_reg : s3_dyn_reg;
    // on the clipping axis the point is the edge itself: base +/- n
    assign s4_exact_next = eneg ? ebase - sel_n : ebase + sel_n;
    assign s4_obase_next = sel_x ? s3_ay_reg : s3_ax_reg;
    assign s4_oneg_next  = sel_x ? s3_dyn_reg : s3_dxn_reg;
    assign s4_omag_next  = sel_x ? s3_ady_reg : s3_adx_reg;

    logic         s4_valid_reg, s4_hit_reg, s4_selx_reg, s4_oneg_reg;
    logic [C-1:0] s4_n_reg, s4_d_reg, s4_exact_reg, s4_obase_reg, s4_omag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (en)
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_hit_reg   <= s4_hit_next;
            s4_selx_reg  <= sel_x;
            s4_n_reg     <= sel_n;
            s4_d_reg     <= s4_d_next;
            s4_exact_reg <= s4_exact_next;
            s4_obase_reg <= s4_obase_next;
            s4_oneg_reg  <= s4_oneg_next;
            s4_omag_reg  <= s4_omag_next;
        end
    end

    // ---------------- stage 5: n * |delta| on the other axis
    logic [2*C-1:0] s5_prod_next;
    logic [SW-1:0]  s5_side_next;

    assign s5_prod_next = s4_n_reg * s4_omag_reg;
    assign s5_side_next = {s4_hit_reg, s4_selx_reg, s4_exact_reg, s4_obase_reg, s4_oneg_reg};

    logic           s5_valid_reg;
    logic [2*C-1:0] s5_prod_reg;
    logic [C-1:0]   s5_d_reg;
    logic [SW-1:0]  s5_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else if (en)
            s5_valid_reg <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_prod_reg <= s5_prod_next;
            s5_d_reg    <= s4_d_reg;
            s5_side_reg <= s5_side_next;
        end
    end

    // ---------------- divider and output
    logic          dv_valid, dv_rem_nz;
    logic [C-1:0]  dv_quo;
    logic [SW-1:0] dv_side;

    srci_div #(
        .W  (C),
        .SW (SW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s5_valid_reg),
        .num       (s5_prod_reg),
        .den       (s5_d_reg),
        .side      (s5_side_reg),
        .out_valid (dv_valid),
        .quo       (dv_quo),
        .rem_nz    (dv_rem_nz),
        .out_side  (dv_side)
    );

    logic         f_hit, f_selx, f_oneg;
    logic [C-1:0] f_exact, f_obase, f_other;
    srci_pkg::seg_out_t out_data_next;

    assign {f_hit, f_selx, f_exact, f_obase, f_oneg} = dv_side;
    // floor toward minus infinity on a negative delta
    assign f_other = f_oneg ? f_obase - dv_quo - {{(C-1){1'b0}}, dv_rem_nz}
                            : f_obase + dv_quo;

    always_comb
    begin
        out_data_next.hit     = f_hit;
        out_data_next.cross_x = '0;
        out_data_next.cross_y = '0;
        if (f_hit)
        begin
            out_data_next.cross_x = f_selx ? f_exact : f_other;
            out_data_next.cross_y = f_selx ? f_other : f_exact;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= out_data_next;
    end

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(s1_valid_reg) && $stable(out_valid_reg))
        else $error("pipeline advanced while stalled");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> s1_valid_reg)
        else $error("accepted item missing from first stage");

    a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
        en |=> out_valid_reg == $past(dv_valid))
        else $error("output valid does not follow divider");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.hit |-> out_data_reg.cross_x == 0
            && out_data_reg.cross_y == 0)
        else $error("crossing point not zero on a miss");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`default_nettype none

module tb_top;

    localparam int LATENCY = 30;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    srci_pkg::seg_in_t  in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    srci_pkg::seg_out_t out_data;

    srci_pkg::seg_in_t  pending_segs[$];
    srci_pkg::seg_out_t expected_crossings[$];
    int       error_count = 0;
    int       sent_count = 0;
    int       hit_count = 0;
    int       checked_count = 0;
    bit       quiet_phase = 1'b0;
    bit       hold_done = 1'b0;
    bit       in_taken = 1'b0;
    int       hold_left = 0;
    int       in_gap = 0;
    int       out_gap = 0;

    segment_rectangle_clip_intersect u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #6 clk = ~clk;

    // sign of n1/d1 - n2/d2 with positive denominators; magnitudes stay well under 64 bits
    function automatic int compare_ratio(longint n1, longint d1, longint n2, longint d2);
        logic signed [127:0] lhs;
        logic signed [127:0] rhs;
        begin
            lhs = 128'(n1) * 128'(d2);
            rhs = 128'(n2) * 128'(d1);
            if (lhs > rhs)
                return 1;
            if (lhs < rhs)
                return -1;
            return 0;
        end
    endfunction

    // base + floor(num*delta/den)
    function automatic logic signed [23:0] walk_along(longint base, longint delta,
                                                        longint num, longint den);
        logic signed [127:0] prod;
        logic signed [127:0] quo;
        begin
            prod = 128'(num) * 128'(delta);
            quo = prod / 128'(den);
            if (prod < 0 && quo * 128'(den) != prod)
                quo = quo - 1;
            return 24'(base + longint'(quo));
        end
    endfunction

    function automatic srci_pkg::seg_out_t clip_crossing(srci_pkg::seg_in_t s);
        srci_pkg::seg_out_t r;
        longint   ax, ay, dx, dy, p[4], q[4];
        longint   n0, d0, n1, d1, n, d;
        bit       rejected;
        begin
            ax = longint'(s.start_x);
            ay = longint'(s.start_y);
            dx = longint'(s.end_x) - ax;
            dy = longint'(s.end_y) - ay;
            p[0] = -dx; q[0] = ax - longint'(s.rect_left);
            p[1] = dx;  q[1] = longint'(s.rect_left) + longint'({1'b0, s.rect_width}) - ax;
            p[2] = -dy; q[2] = ay - longint'(s.rect_bottom);
            p[3] = dy;  q[3] = longint'(s.rect_bottom) + longint'({1'b0, s.rect_height}) - ay;
            n0 = 0; d0 = 1; n1 = 1; d1 = 1;
            rejected = 1'b0;
            r = '0;
            for (int e = 0; e < 4; e++) begin
                if (rejected)
                    break;
                if (p[e] == 0) begin
                    if (q[e] < 0)
                        rejected = 1'b1;
                end else if (p[e] < 0) begin
                    if (compare_ratio(-q[e], -p[e], n1, d1) > 0)
                        rejected = 1'b1;
                    else if (compare_ratio(-q[e], -p[e], n0, d0) > 0) begin
                        n0 = -q[e]; d0 = -p[e];
                    end
                end else begin
                    if (compare_ratio(q[e], p[e], n0, d0) < 0)
                        rejected = 1'b1;
                    else if (compare_ratio(q[e], p[e], n1, d1) < 0) begin
                        n1 = q[e]; d1 = p[e];
                    end
                end
            end
            if (rejected)
                return r;
            if (n0 > 0 && n0 < d0) begin
                n = n0; d = d0;
            end else if (n1 > 0 && n1 < d1) begin
                n = n1; d = d1;
            end else begin
                return r;
            end
            r.hit = 1'b1;
            r.cross_x = walk_along(ax, dx, n, d);
            r.cross_y = walk_along(ay, dy, n, d);
            return r;
        end
    endfunction

    task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
        begin
            $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
            error_count++;
        end
    endtask

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 24'(int'($urandom_range(0, 4000)) - 2000);
            1: return 24'h7fffff - 24'($urandom_range(0, 3));
            2: return 24'h800000 + 24'($urandom_range(0, 3));
            3: return 24'($urandom_range(0, 255) << $urandom_range(0, 15));
            default: return 24'($urandom);
        endcase
    endfunction

    // build a segment near the rectangle so most items clip somewhere
    function automatic srci_pkg::seg_in_t rand_segment();
        srci_pkg::seg_in_t s;
        int      span;
        begin
            if ($urandom_range(0, 9) < 2) begin
                s.start_x     = 24'($urandom);
                s.start_y     = 24'($urandom);
                s.end_x       = 24'($urandom);
                s.end_y       = 24'($urandom);
                s.rect_left   = 24'($urandom);
                s.rect_bottom = 24'($urandom);
                s.rect_width  = 23'($urandom);
                s.rect_height = 23'($urandom);
                return s;
            end
            span = 1 << $urandom_range(2, 20);
            s.rect_left   = 24'(int'($urandom_range(0, 2 * span)) - span);
            s.rect_bottom = 24'(int'($urandom_range(0, 2 * span)) - span);
            s.rect_width  = 23'($urandom_range(0, span));
            s.rect_height = 23'($urandom_range(0, span));
            s.start_x = 24'(int'($urandom_range(0, 4 * span)) - 2 * span);
            s.start_y = 24'(int'($urandom_range(0, 4 * span)) - 2 * span);
            case ($urandom_range(0, 4))
                0: s.end_x = s.start_x;
                1: s.end_x = s.rect_left;
                default: s.end_x = 24'(int'($urandom_range(0, 4 * span)) - 2 * span);
            endcase
            case ($urandom_range(0, 4))
                0: s.end_y = s.start_y;
                1: s.end_y = s.rect_bottom + 24'(s.rect_height);
                default: s.end_y = 24'(int'($urandom_range(0, 4 * span)) - 2 * span);
            endcase
            if ($urandom_range(0, 7) == 0)
                s.start_x = rand_coord();
            if ($urandom_range(0, 7) == 0)
                s.end_y = rand_coord();
            return s;
        end
    endfunction

    function automatic srci_pkg::seg_in_t make_seg(int sx, int sy, int ex, int ey,
                                                   int rl, int rb, int rw, int rh);
        srci_pkg::seg_in_t s;
        begin
            s.start_x = 24'(sx); s.start_y = 24'(sy);
            s.end_x = 24'(ex); s.end_y = 24'(ey);
            s.rect_left = 24'(rl); s.rect_bottom = 24'(rb);
            s.rect_width = 23'(rw); s.rect_height = 23'(rh);
            return s;
        end
    endfunction

    initial begin
        // crossing left edge, exit only, wholly inside, endpoint touch
        pending_segs.push_back(make_seg(-512, 128, 512, 128, 0, 0, 256, 256));
        pending_segs.push_back(make_seg(128, 128, 1024, 700, 0, 0, 256, 256));
        pending_segs.push_back(make_seg(10, 10, 200, 200, 0, 0, 256, 256));
        pending_segs.push_back(make_seg(-256, 0, 0, 0, 0, 0, 256, 256));
        pending_segs.push_back(make_seg(256, 256, 512, 512, 0, 0, 256, 256));
        // parallel outside, parallel on an edge, degenerate
        pending_segs.push_back(make_seg(-100, 300, 500, 300, 0, 0, 256, 256));
        pending_segs.push_back(make_seg(-100, 256, 500, 256, 0, 0, 256, 256));
        pending_segs.push_back(make_seg(50, 50, 50, 50, 0, 0, 256, 256));
        pending_segs.push_back(make_seg(-50, -50, -50, -50, 0, 0, 256, 256));
        // zero-size rectangle, negative slope rounding
        pending_segs.push_back(make_seg(-100, -100, 100, 100, 0, 0, 0, 0));
        pending_segs.push_back(make_seg(-100, 0, 100, 0, 0, 0, 0, 0));
        pending_segs.push_back(make_seg(300, 7, -300, -3, 0, -100, 100, 200));
        pending_segs.push_back(make_seg(1, 500, 4, -500, 0, 0, 100, 100));
        // field extremes
        pending_segs.push_back(make_seg(-8388608, -8388608, 8388607, 8388607,
                                        -8388608, -8388608, 8388607, 8388607));
        pending_segs.push_back(make_seg(8388607, -8388608, -8388608, 8388607,
                                        0, 0, 8388607, 8388607));
        pending_segs.push_back(make_seg(-8388608, 0, 8388607, 0, 8388607, -5, 8388607, 10));
        pending_segs.push_back(make_seg(0, 0, 0, 0, 0, 0, 0, 0));
        pending_segs.push_back(make_seg(-1, -1, -1, -1, -1, -1, 8388607, 8388607));
        pending_segs.push_back(make_seg(-8388608, 100, 8388607, 101, -1000, 0, 2000, 8388607));
        for (int i = 0; i < 750; i++)
            pending_segs.push_back(rand_segment());
    end

    initial begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // record each item at the edge that accepts it
    always @(posedge clk) begin
        in_taken = rst_n && in_valid && !in_stall;
        if (in_taken) begin
            expected_crossings.push_back(clip_crossing(in_data));
            sent_count++;
        end
    end

    // driver: hold payload while stalled, advance on acceptance
    always @(negedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_taken) begin
                // hold
            end else if (in_gap > 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end else if (pending_segs.size() > 0) begin
                if (!quiet_phase && $urandom_range(0, 15) == 0) begin
                    in_gap = $urandom_range(1, 18);
                    in_valid <= 1'b0;
                end else begin
                    in_data <= pending_segs.pop_front();
                    in_valid <= 1'b1;
                end
            end else begin
                in_valid <= 1'b0;
            end
            quiet_phase <= pending_segs.size() < 100;
        end
    end

    // receiver stall: random bursts plus one long hold-off
    always @(negedge clk) begin
        if (rst_n) begin
            if (!hold_done && sent_count >= 200) begin
                hold_done = 1'b1;
                hold_left = 200;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (out_gap > 0) begin
                out_gap--;
                out_stall <= 1'b1;
            end else if (!quiet_phase && $urandom_range(0, 15) == 0) begin
                out_gap = $urandom_range(1, 18);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        srci_pkg::seg_out_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_crossings.size() == 0) begin
                report_mismatch("unexpected item", 48'(out_data), 48'h0);
            end else begin
                want = expected_crossings.pop_front();
                if (out_data.hit !== want.hit)
                    report_mismatch("hit", 48'(out_data.hit), 48'(want.hit));
                if (out_data.cross_x !== want.cross_x)
                    report_mismatch("cross_x", 48'(out_data.cross_x), 48'(want.cross_x));
                if (out_data.cross_y !== want.cross_y)
                    report_mismatch("cross_y", 48'(out_data.cross_y), 48'(want.cross_y));
                hit_count += want.hit;
                checked_count++;
            end
        end
    end

    initial begin
        wait (rst_n);
        wait (pending_segs.size() == 0 && !in_valid);
        wait (expected_crossings.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        $display("Checked %0d segments against rectangles, %0d with a crossing point,",
                 checked_count, hit_count);
        $display("including endpoint touches, parallel edges, degenerate and extreme cases.");
        if (error_count == 0 && expected_crossings.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #2000000;
        $display("Timeout waiting for results");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
sv/srci_pkg.sv
sv/srci_div.sv
sv/segment_rectangle_clip_intersect.sv
bench/tb_top.sv
